// ===== sv/rdsc_pkg.sv =====
// shared types, widths and the digit character table for the radix converter
package rdsc_pkg;

  localparam int VALUE_W   = 32;
  localparam int MAG_W     = 31;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 7;
  localparam int DIV_STEPS = MAG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  typedef struct packed {
    logic               start;
    logic [MAG_W-1:0]   dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [MAG_W-1:0]   quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_rsp_t;

  // digit to uppercase ascii
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    case (d)
      4'd0:    c = 7'h30;
      4'd1:    c = 7'h31;
      4'd2:    c = 7'h32;
      4'd3:    c = 7'h33;
      4'd4:    c = 7'h34;
      4'd5:    c = 7'h35;
      4'd6:    c = 7'h36;
      4'd7:    c = 7'h37;
      4'd8:    c = 7'h38;
      4'd9:    c = 7'h39;
      4'd10:   c = 7'h41;
      4'd11:   c = 7'h42;
      4'd12:   c = 7'h43;
      4'd13:   c = 7'h44;
      4'd14:   c = 7'h45;
      default: c = 7'h46;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/rdsc_divider.sv =====
// restoring divider, one quotient bit per cycle, 31-bit dividend by a small radix
module rdsc_divider (
  input  logic               clk,
  input  logic               rst,
  input  rdsc_pkg::div_req_t req,
  output rdsc_pkg::div_rsp_t rsp
);

  logic                            busy;
  logic                            done;
  logic [rdsc_pkg::STEP_W-1:0]     step;
  logic [rdsc_pkg::MAG_W-1:0]      quo;
  logic [rdsc_pkg::DIGIT_W-1:0]    rem;
  logic [rdsc_pkg::RADIX_W-1:0]    divisor;

  logic [rdsc_pkg::RADIX_W-1:0]    shifted;
  logic                            ge;
  logic [rdsc_pkg::RADIX_W-1:0]    diff;

  // partial remainder stays below the divisor, so four bits hold it
  assign shifted = {rem, quo[rdsc_pkg::MAG_W-1]};
  assign ge      = (shifted >= divisor);
  assign diff    = shifted - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == rdsc_pkg::STEP_W'(rdsc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[rdsc_pkg::MAG_W-2:0], ge};
      rem <= ge ? diff[rdsc_pkg::DIGIT_W-1:0] : shifted[rdsc_pkg::DIGIT_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== sv/rdsc_digit_stack.sv =====
// digit stack storage, one write and one registered read port
module rdsc_digit_stack #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [rdsc_pkg::DIGIT_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [rdsc_pkg::DIGIT_W-1:0] rd_data
);

  logic [rdsc_pkg::DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/radix_digit_string_converter.sv =====
// top level: converts a positive value to an ascii digit string in radix 2..16
//
// input channel (in_valid/in_ready) carries value and radix; output channel
// (out_valid/out_ready) carries digit_char and last_digit, most significant
// digit first, last_digit set on the final one.
// a zero or negative value, or a radix outside 2..16, is taken and dropped
// without any output item.
// in_ready is high only while the block is idle; one item is worked at a time.
// each digit is worked out on the shared bit-serial divider, then every
// digit is popped from the stack (S_RD) and shown on the output (S_OUT);
// at most 31 binary digits are made for one item.
// a stalled receiver simply holds the current digit on the output; nothing is
// lost and the next digit is read only after the held one is taken.
// synchronous active-high rst returns the sequencer to idle with the stack
// empty; the stack memory itself is not cleared.
module radix_digit_string_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rdsc_pkg::VALUE_W-1:0] value,
  input  logic [rdsc_pkg::RADIX_W-1:0]        radix,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rdsc_pkg::CHAR_W-1:0]         digit_char,
  output logic                                last_digit
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_RD   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [LW-1:0]                  level;
  logic [LW-1:0]                  level_next;
  logic [LW-1:0]                  level_dec;
  logic [rdsc_pkg::RADIX_W-1:0]   radix_q;

  rdsc_pkg::div_req_t             req;
  rdsc_pkg::div_rsp_t             rsp;

  logic                           in_fire;
  logic                           in_ok;
  logic                           wr_en;
  logic                           rd_en;
  logic [rdsc_pkg::DIGIT_W-1:0]   rd_data;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_ok     = !value[rdsc_pkg::VALUE_W-1] && (value != '0)
                     && (radix inside {[rdsc_pkg::RADIX_MIN:rdsc_pkg::RADIX_MAX]});
  assign level_dec = level - 1'b1;

  // next dividend is the quotient just produced, until it reaches zero
  always_comb begin
    req.start    = 1'b0;
    req.dividend = rsp.quotient;
    req.divisor  = radix_q;
    if (state == S_IDLE) begin
      req.start    = in_fire && in_ok;
      req.dividend = value[rdsc_pkg::MAG_W-1:0];
      req.divisor  = radix;
    end else if (state == S_DIV) begin
      req.start    = rsp.done && (rsp.quotient != '0);
    end
  end

  assign wr_en = (state == S_DIV) && rsp.done;
  assign rd_en = (state == S_RD);

  always_comb begin
    state_next = state;
    level_next = level;
    case (state)
      S_IDLE: begin
        level_next = '0;
        if (in_fire && in_ok) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (rsp.done) begin
          level_next = level + 1'b1;
          if (rsp.quotient == '0) begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        level_next = level_dec;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = (level == '0) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
        level_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      level <= '0;
    end else begin
      state <= state_next;
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      radix_q <= radix;
    end
  end

  rdsc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  rdsc_digit_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (level[AW-1:0]),
    .wr_data (rsp.remainder),
    .rd_en   (rd_en),
    .rd_addr (level_dec[AW-1:0]),
    .rd_data (rd_data)
  );

  assign out_valid  = (state == S_OUT);
  assign digit_char = rdsc_pkg::digit_to_char(rd_data);
  assign last_digit = (level == '0);

endmodule
